// ===== hdl/fec_pkg.sv =====
// Shared types, codes and sizes for the file event coalescer.
package fec_pkg;

   localparam int TABLE_DEPTH          = 32;
   localparam int ADDR_BITS            = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS             = $clog2(TABLE_DEPTH + 1);
   localparam int DEF_RESCAN_THRESHOLD = 32;
   localparam int DEF_NAME_BITS        = 16;
   localparam int KIND_BITS            = 4;
   localparam int RES_BITS             = 3;
   localparam int ID_BITS              = 16;
   localparam int TICK_BITS            = 16;
   localparam int ST_BITS              = 3;
   localparam int CSR_ADDR_BITS        = 3;
   localparam int CSR_DATA_BITS        = 32;

   localparam logic [TICK_BITS-1:0] DEBOUNCE_RESET = 16'd150;

   // input event kinds
   localparam logic [KIND_BITS-1:0] K_CREATED  = 4'd0;
   localparam logic [KIND_BITS-1:0] K_DELETED  = 4'd1;
   localparam logic [KIND_BITS-1:0] K_MODIFIED = 4'd2;
   localparam logic [KIND_BITS-1:0] K_ATTRS    = 4'd3;
   localparam logic [KIND_BITS-1:0] K_MFROM    = 4'd4;
   localparam logic [KIND_BITS-1:0] K_MTO      = 4'd5;
   localparam logic [KIND_BITS-1:0] K_GONE     = 4'd6;
   localparam logic [KIND_BITS-1:0] K_OVERFLOW = 4'd7;
   localparam logic [KIND_BITS-1:0] K_TICK     = 4'd8;
   localparam logic [KIND_BITS-1:0] K_FLUSH    = 4'd9;
   localparam logic [KIND_BITS-1:0] K_DISCARD  = 4'd10;

   // per-entry states
   localparam logic [ST_BITS-1:0] ST_NONE     = 3'd0;
   localparam logic [ST_BITS-1:0] ST_CREATED  = 3'd1;
   localparam logic [ST_BITS-1:0] ST_DELETED  = 3'd2;
   localparam logic [ST_BITS-1:0] ST_MODIFIED = 3'd3;
   localparam logic [ST_BITS-1:0] ST_MFROM    = 3'd4;
   localparam logic [ST_BITS-1:0] ST_MTO      = 3'd5;

   // result kinds
   localparam logic [RES_BITS-1:0] R_CREATED  = 3'd0;
   localparam logic [RES_BITS-1:0] R_DELETED  = 3'd1;
   localparam logic [RES_BITS-1:0] R_MODIFIED = 3'd2;
   localparam logic [RES_BITS-1:0] R_RENAMED  = 3'd3;
   localparam logic [RES_BITS-1:0] R_RESCAN   = 3'd4;
   localparam logic [RES_BITS-1:0] R_GONE     = 3'd5;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_DEBOUNCE = 3'd0;

   typedef enum logic [1:0] {
      TERM_NONE     = 2'd0,
      TERM_OVERFLOW = 2'd1,
      TERM_GONE     = 2'd2
   } term_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] ptr;
      logic                found;
      logic                exhausted;
   } scan_stat_type;

endpackage

// ===== hdl/file_event_coalescer.sv =====
// Top level of the file event coalescer: event sequencer, flush run and CSR port.
//
// Gathers per-name change events in a 32-entry table held in one RAM with two
// registered read ports, and on flush emits the net change as a stream of
// results, the final one marked by rsp_last. An event is accepted, then its
// name is searched for linearly; a delete that cancels a create moves each
// later entry down to close the gap. Ticks, discards and ignored kinds need
// no search. A flush walks the table with two scanners (one per read port):
// one walk for rename pairs and leftover halves, a second for the plain
// entries, unless it emits a single rescan or gone result instead. The result
// register lets the next event be accepted while the final result still waits
// to be taken. debounce_ticks sits at byte address 0.
module file_event_coalescer #(
   parameter int RESCAN_THRESHOLD = fec_pkg::DEF_RESCAN_THRESHOLD,
   parameter int NAME_BITS        = fec_pkg::DEF_NAME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fec_pkg::KIND_BITS-1:0]     req_kind,
   input  logic [fec_pkg::ID_BITS-1:0]       req_name_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fec_pkg::RES_BITS-1:0]      rsp_kind_res,
   output logic [fec_pkg::ID_BITS-1:0]       rsp_name_id_res,
   output logic [fec_pkg::ID_BITS-1:0]       rsp_new_name_id,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fec_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [fec_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [fec_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int EC_BITS       = $clog2(RESCAN_THRESHOLD + 2);
   localparam int WORD_BITS     = fec_pkg::ST_BITS + NAME_BITS;
   localparam int CNT_BITS      = fec_pkg::CNT_BITS;
   localparam int ADDR_BITS     = fec_pkg::ADDR_BITS;
   localparam int ID_BITS       = fec_pkg::ID_BITS;
   localparam int RES_BITS      = fec_pkg::RES_BITS;
   localparam int ST_BITS       = fec_pkg::ST_BITS;
   localparam int CSR_DATA_BITS = fec_pkg::CSR_DATA_BITS;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SEARCH  = 9'b000000010,
      S_COMPACT = 9'b000000100,
      S_FSTART  = 9'b000001000,
      S_PAIR    = 9'b000010000,
      S_FROM    = 9'b000100000,
      S_TO      = 9'b001000000,
      S_PLAIN   = 9'b010000000,
      S_END     = 9'b100000000
   } state_type;

   state_type                       state_ff, state_in;
   logic [fec_pkg::TICK_BITS-1:0]   debounce_ff, debounce_in;
   logic [fec_pkg::TICK_BITS-1:0]   countdown_ff, countdown_in;
   logic                            running_ff, running_in;
   logic [EC_BITS-1:0]              ec_ff, ec_in;
   fec_pkg::term_type               term_ff, term_in;
   logic [CNT_BITS-1:0]             count_ff, count_in;
   logic [fec_pkg::KIND_BITS-1:0]   kind_ff, kind_in;
   logic [NAME_BITS-1:0]            name_ff, name_in;

   logic                            hold_v_ff, hold_v_in;
   logic [RES_BITS-1:0]             hold_kind_ff, hold_kind_in;
   logic [ID_BITS-1:0]              hold_a_ff, hold_a_in;
   logic [ID_BITS-1:0]              hold_b_ff, hold_b_in;

   logic                            out_v_ff, out_v_in;
   logic [RES_BITS-1:0]             out_kind_ff, out_kind_in;
   logic [ID_BITS-1:0]              out_a_ff, out_a_in;
   logic [ID_BITS-1:0]              out_b_ff, out_b_in;
   logic                            out_last_ff, out_last_in;

   logic                            wr_en;
   logic [ADDR_BITS-1:0]            wr_addr;
   logic [WORD_BITS-1:0]            wr_data;
   logic [WORD_BITS-1:0]            rdata_a, rdata_b;
   logic [ST_BITS-1:0]              a_state, b_state, cur, nst;
   logic [NAME_BITS-1:0]            a_name, b_name;

   logic                            f_load, t_load, f_match, t_match, f_consume, t_consume;
   logic [CNT_BITS-1:0]             f_load_ptr;
   fec_pkg::scan_stat_type          f_stat, t_stat;

   logic                            out_free, gen_ok, gen, post, do_note, clear;
   logic [RES_BITS-1:0]             gen_kind;
   logic [ID_BITS-1:0]              gen_a, gen_b;
   logic                            csr_wr, accept;

   fec_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (fec_pkg::TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (f_stat.ptr[ADDR_BITS-1:0]),
      .rd_data_a (rdata_a),
      .rd_addr_b (t_stat.ptr[ADDR_BITS-1:0]),
      .rd_data_b (rdata_b)
   );

   // scanner f: name search, compaction, moved_from and plain passes
   fec_scan u_scan_f (
      .clock    (clock),
      .reset    (reset),
      .load     (f_load),
      .load_ptr (f_load_ptr),
      .count    (count_ff),
      .match    (f_match),
      .consume  (f_consume),
      .stat     (f_stat)
   );

   // scanner t: moved_to entries
   fec_scan u_scan_t (
      .clock    (clock),
      .reset    (reset),
      .load     (t_load),
      .load_ptr ('0),
      .count    (count_ff),
      .match    (t_match),
      .consume  (t_consume),
      .stat     (t_stat)
   );

   assign a_state = rdata_a[NAME_BITS +: ST_BITS];
   assign a_name  = rdata_a[NAME_BITS-1:0];
   assign b_state = rdata_b[NAME_BITS +: ST_BITS];
   assign b_name  = rdata_b[NAME_BITS-1:0];

   assign req_ready  = state_ff == S_IDLE;
   assign accept     = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DATA_BITS'(debounce_ff);

   assign rsp_valid       = out_v_ff;
   assign rsp_kind_res    = out_kind_ff;
   assign rsp_name_id_res = out_a_ff;
   assign rsp_new_name_id = out_b_ff;
   assign rsp_last        = out_last_ff;

   assign out_free = !out_v_ff || rsp_ready;
   assign gen_ok   = !hold_v_ff || out_free;

   // scanner match per phase
   always_comb begin
      unique case (state_ff)
         S_SEARCH:        f_match = a_name == name_ff;
         S_COMPACT:       f_match = 1'b1;
         S_PAIR, S_FROM:  f_match = a_state == fec_pkg::ST_MFROM;
         S_PLAIN:         f_match = (a_state == fec_pkg::ST_CREATED) ||
                                    (a_state == fec_pkg::ST_DELETED) ||
                                    (a_state == fec_pkg::ST_MODIFIED);
         default:         f_match = 1'b0;
      endcase
      t_match = b_state == fec_pkg::ST_MTO;
   end

   always_comb begin
      state_in     = state_ff;
      debounce_in  = debounce_ff;
      countdown_in = countdown_ff;
      running_in   = running_ff;
      ec_in        = ec_ff;
      term_in      = term_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      name_in      = name_ff;
      f_load       = 1'b0;
      t_load       = 1'b0;
      f_load_ptr   = '0;
      f_consume    = 1'b0;
      t_consume    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = f_stat.ptr[ADDR_BITS-1:0];
      wr_data      = rdata_a;
      gen          = 1'b0;
      gen_kind     = fec_pkg::R_CREATED;
      gen_a        = '0;
      gen_b        = '0;
      post         = 1'b0;
      do_note      = 1'b0;
      clear        = 1'b0;
      cur          = fec_pkg::ST_NONE;
      nst          = fec_pkg::ST_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               name_in = NAME_BITS'(req_name_id);
               priority if (req_kind <= fec_pkg::K_OVERFLOW) begin
                  if (ec_ff <= EC_BITS'(RESCAN_THRESHOLD)) begin
                     ec_in = ec_ff + 1'b1;
                  end
                  f_load   = 1'b1;
                  state_in = S_SEARCH;
               end else if (req_kind == fec_pkg::K_TICK) begin
                  if (running_ff) begin
                     if (countdown_ff <= 16'd1) begin
                        state_in = S_FSTART;
                     end else begin
                        countdown_in = countdown_ff - 1'b1;
                     end
                  end
               end else if (req_kind == fec_pkg::K_FLUSH) begin
                  state_in = S_FSTART;
               end else if (req_kind == fec_pkg::K_DISCARD) begin
                  clear        = 1'b1;
                  countdown_in = '0;
                  running_in   = 1'b0;
               end else begin
                  // unused kinds: drop
               end
            end
         end

         S_SEARCH: begin
            if (term_ff != fec_pkg::TERM_NONE || kind_ff > fec_pkg::K_MTO) begin
               if (term_ff == fec_pkg::TERM_NONE) begin
                  term_in = (kind_ff == fec_pkg::K_GONE) ? fec_pkg::TERM_GONE
                                                         : fec_pkg::TERM_OVERFLOW;
               end
               post = 1'b1;
            end else if (f_stat.found || f_stat.exhausted) begin
               cur  = f_stat.found ? a_state : fec_pkg::ST_NONE;
               post = 1'b1;
               unique case (kind_ff)
                  fec_pkg::K_CREATED: begin
                     do_note = 1'b1;
                     nst = (cur == fec_pkg::ST_DELETED) ? fec_pkg::ST_MODIFIED
                                                        : fec_pkg::ST_CREATED;
                  end
                  fec_pkg::K_DELETED: begin
                     if (cur == fec_pkg::ST_CREATED) begin
                        // cancel: close the gap from the entry after it
                        post       = 1'b0;
                        f_load     = 1'b1;
                        f_load_ptr = f_stat.ptr + 1'b1;
                        state_in   = S_COMPACT;
                     end else begin
                        do_note = 1'b1;
                        nst     = fec_pkg::ST_DELETED;
                     end
                  end
                  fec_pkg::K_MODIFIED, fec_pkg::K_ATTRS: begin
                     do_note = cur != fec_pkg::ST_CREATED;
                     nst     = fec_pkg::ST_MODIFIED;
                  end
                  fec_pkg::K_MFROM: begin
                     do_note = 1'b1;
                     nst     = fec_pkg::ST_MFROM;
                  end
                  default: begin
                     do_note = 1'b1;
                     nst     = fec_pkg::ST_MTO;
                  end
               endcase
               if (do_note) begin
                  wr_data = {nst, name_ff};
                  if (f_stat.found) begin
                     wr_en = 1'b1;
                  end else if (count_ff >= CNT_BITS'(fec_pkg::TABLE_DEPTH)) begin
                     term_in = fec_pkg::TERM_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[ADDR_BITS-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end

         S_COMPACT: begin
            if (f_stat.exhausted) begin
               count_in = count_ff - 1'b1;
               post     = 1'b1;
            end else if (f_stat.found) begin
               wr_en     = 1'b1;
               wr_addr   = f_stat.ptr[ADDR_BITS-1:0] - 1'b1;
               f_consume = 1'b1;
            end
         end

         S_FSTART: begin
            running_in   = 1'b0;
            countdown_in = '0;
            f_load       = 1'b1;
            t_load       = 1'b1;
            priority if (ec_ff == '0) begin
               clear    = 1'b1;
               state_in = S_IDLE;
            end else if (ec_ff > EC_BITS'(RESCAN_THRESHOLD) ||
                         term_ff == fec_pkg::TERM_OVERFLOW) begin
               gen      = 1'b1;
               gen_kind = fec_pkg::R_RESCAN;
               state_in = S_END;
            end else if (term_ff == fec_pkg::TERM_GONE) begin
               gen      = 1'b1;
               gen_kind = fec_pkg::R_GONE;
               state_in = S_END;
            end else begin
               state_in = S_PAIR;
            end
         end

         S_PAIR: begin
            if (f_stat.exhausted || t_stat.exhausted) begin
               state_in = S_FROM;
            end else if (f_stat.found && t_stat.found && gen_ok) begin
               gen       = 1'b1;
               gen_kind  = fec_pkg::R_RENAMED;
               gen_a     = ID_BITS'(a_name);
               gen_b     = ID_BITS'(b_name);
               f_consume = 1'b1;
               t_consume = 1'b1;
            end
         end

         S_FROM: begin
            if (f_stat.exhausted) begin
               state_in = S_TO;
            end else if (f_stat.found && gen_ok) begin
               gen       = 1'b1;
               gen_kind  = fec_pkg::R_DELETED;
               gen_a     = ID_BITS'(a_name);
               f_consume = 1'b1;
            end
         end

         S_TO: begin
            if (t_stat.exhausted) begin
               f_load   = 1'b1;
               state_in = S_PLAIN;
            end else if (t_stat.found && gen_ok) begin
               gen       = 1'b1;
               gen_kind  = fec_pkg::R_CREATED;
               gen_a     = ID_BITS'(b_name);
               t_consume = 1'b1;
            end
         end

         S_PLAIN: begin
            if (f_stat.exhausted) begin
               state_in = S_END;
            end else if (f_stat.found && gen_ok) begin
               gen       = 1'b1;
               gen_a     = ID_BITS'(a_name);
               f_consume = 1'b1;
               unique case (a_state)
                  fec_pkg::ST_CREATED: gen_kind = fec_pkg::R_CREATED;
                  fec_pkg::ST_DELETED: gen_kind = fec_pkg::R_DELETED;
                  default:             gen_kind = fec_pkg::R_MODIFIED;
               endcase
            end
         end

         S_END: begin
            // release the held result as the final one, then drop the burst
            if (!hold_v_ff || out_free) begin
               clear    = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (post) begin
         if (kind_ff == fec_pkg::K_GONE) begin
            state_in = S_FSTART;
         end else begin
            countdown_in = debounce_ff;
            running_in   = 1'b1;
            state_in     = S_IDLE;
         end
      end

      if (clear) begin
         count_in = '0;
         ec_in    = '0;
         term_in  = fec_pkg::TERM_NONE;
      end

      if (csr_wr) begin
         debounce_in = csr_pwdata[fec_pkg::TICK_BITS-1:0];
         if (running_ff) begin
            countdown_in = csr_pwdata[fec_pkg::TICK_BITS-1:0];
         end
      end
   end

   // hold stage and result register: a result leaves the hold stage only
   // when the next one arrives or the run ends, so last is known
   always_comb begin
      hold_v_in    = hold_v_ff;
      hold_kind_in = hold_kind_ff;
      hold_a_in    = hold_a_ff;
      hold_b_in    = hold_b_ff;
      out_v_in     = out_v_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      out_last_in  = out_last_ff;
      if ((gen && hold_v_ff) || (state_ff == S_END && hold_v_ff && out_free)) begin
         out_v_in    = 1'b1;
         out_kind_in = hold_kind_ff;
         out_a_in    = hold_a_ff;
         out_b_in    = hold_b_ff;
         out_last_in = !gen;
         hold_v_in   = 1'b0;
      end
      if (gen) begin
         hold_v_in    = 1'b1;
         hold_kind_in = gen_kind;
         hold_a_in    = gen_a;
         hold_b_in    = gen_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         debounce_ff  <= fec_pkg::DEBOUNCE_RESET;
         countdown_ff <= '0;
         running_ff   <= 1'b0;
         ec_ff        <= '0;
         term_ff      <= fec_pkg::TERM_NONE;
         count_ff     <= '0;
         hold_v_ff    <= 1'b0;
         out_v_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         debounce_ff  <= debounce_in;
         countdown_ff <= countdown_in;
         running_ff   <= running_in;
         ec_ff        <= ec_in;
         term_ff      <= term_in;
         count_ff     <= count_in;
         hold_v_ff    <= hold_v_in;
         out_v_ff     <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      name_ff      <= name_in;
      hold_kind_ff <= hold_kind_in;
      hold_a_ff    <= hold_a_in;
      hold_b_ff    <= hold_b_in;
      out_kind_ff  <= out_kind_in;
      out_a_ff     <= out_a_in;
      out_b_ff     <= out_b_in;
      out_last_ff  <= out_last_in;
   end

endmodule

// ===== hdl/fec_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module fec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== hdl/fec_scan.sv =====
// Table scanner: walks a read pointer until the entry under it matches.
module fec_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [fec_pkg::CNT_BITS-1:0] load_ptr,
   input  logic [fec_pkg::CNT_BITS-1:0] count,
   input  logic                         match,
   input  logic                         consume,
   output fec_pkg::scan_stat_type       stat
);

   logic [fec_pkg::CNT_BITS-1:0] ptr_ff, ptr_in;
   logic                         vld_ff, vld_in;
   logic                         exh, advance;

   always_comb begin
      exh        = ptr_ff >= count;
      stat.ptr   = ptr_ff;
      stat.exhausted = exh;
      stat.found = vld_ff && !exh && match;
      advance    = !load && (consume || (vld_ff && !exh && !match));
      if (load) begin
         ptr_in = load_ptr;
      end else if (advance) begin
         ptr_in = ptr_ff + 1'b1;
      end else begin
         ptr_in = ptr_ff;
      end
      // read data is valid only when the pointer was neither loaded nor advanced
      vld_in = !load && !advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         vld_ff <= vld_in;
      end
   end

endmodule
